FILE: src/lmfb_pkg.sv
// Shared types, codes and per-LED update functions for the LED matrix scanner.
// Used by lmfb_front, lmfb_back and led_matrix_fade_blink_scanner_unit; no dependencies.
package lmfb_pkg;

  // Duty outputs that exist on the result port.
  localparam int unsigned OUT_ROWS = 3;

  // Input action codes.
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_SET  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // LED mode codes.
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_DIM   = 2'd1;
  localparam logic [1:0] MODE_FULL  = 2'd2;
  localparam logic [1:0] MODE_BLINK = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_FADE_STEP    = 2'd0;
  localparam logic [1:0] REG_FULL_LEVEL   = 2'd1;
  localparam logic [1:0] REG_DIM_LEVEL    = 2'd2;
  localparam logic [1:0] REG_BLINK_PERIOD = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TICK,
    OP_SET,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] idx;
    logic [1:0] mode;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  fade_step;
    logic [7:0]  full_level;
    logic [7:0]  dim_level;
    logic [15:0] blink_period;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  target;
    logic [7:0]  fade;
    logic        blink;
    logic [15:0] timer;
  } led_t;

  function automatic logic [1:0] mode_of(led_t e, cfg_t c);
    logic [1:0] m;
    if (e.blink) begin
      m = MODE_BLINK;
    end else if (e.target == c.full_level) begin
      m = MODE_FULL;
    end else if (e.target == c.dim_level) begin
      m = MODE_DIM;
    end else begin
      m = MODE_OFF;
    end
    return m;
  endfunction

  function automatic led_t set_mode(led_t e, logic [1:0] m, cfg_t c);
    led_t r;
    r = e;
    if (m == MODE_BLINK) begin
      // Blink starts in the phase opposite to what the LED shows now.
      r.blink  = 1'b1;
      r.target = (e.target == c.full_level || e.target == c.dim_level) ? 8'd0 : c.full_level;
    end else begin
      if (e.blink) begin
        r.blink = 1'b0;
        r.timer = 16'd0;
      end
      case (m)
        MODE_OFF: r.target = 8'd0;
        MODE_DIM: r.target = c.dim_level;
        default:  r.target = c.full_level;
      endcase
    end
    return r;
  endfunction

  // Moves the fade level toward the target by step, stopping at the target.
  function automatic logic [7:0] fade_next(logic [7:0] cur, logic [7:0] tgt, logic [7:0] step);
    logic [8:0] sum;
    logic [8:0] dif;
    logic [7:0] r;
    sum = {1'b0, cur} + {1'b0, step};
    dif = {1'b0, cur} - {1'b0, step};
    r   = cur;
    if (cur < tgt) begin
      r = (sum > {1'b0, tgt}) ? tgt : sum[7:0];
    end else if (cur > tgt) begin
      r = (dif[8] || (dif[7:0] < tgt)) ? tgt : dif[7:0];
    end
    return r;
  endfunction

endpackage

FILE: src/led_matrix_fade_blink_scanner_unit.sv
// Top level of the LED matrix scanner with fade and blink: configuration
// registers, command front end and execution back end. Depends on lmfb_pkg,
// lmfb_front and lmfb_back.
//
//  Channel  Direction  Handshake               Contents
//  in       input      in_valid_i/in_ready_o   action_i, led_index_i, led_mode_i
//  out      output     out_valid_o/out_ready_i column_o, row0..2_duty_o, mode_code_o,
//                                              run_time_ms_o
//  cfg      input      cfg_we_i (no stall)     cfg_index_i, cfg_wdata_i
//
// Set and read items pass through S_ONE, S_DRAIN and S_FIN in the back end.
// A scan tick passes S_FADE once per row, then S_DRAIN and S_FIN; on every second
// tick it also passes S_GAP and S_BLINK, where the blink timers of all LEDs are
// walked one entry per cycle through the LED state memory (one read, one write port).
// A two-entry command queue lets items be accepted while the back end is busy,
// and a result register lets the back end work on the next item while a result waits.
// Reset clears all LED state at once through per-entry valid bits; no clearing
// pass is needed. The back end stalls only in its finish step, while a previous
// result has not been taken.
module led_matrix_fade_blink_scanner_unit #(
  parameter int unsigned NUM_COLUMNS = 8,
  parameter int unsigned NUM_ROWS    = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [4:0]  led_index_i,
  input  logic [1:0]  led_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  column_o,
  output logic [7:0]  row0_duty_o,
  output logic [7:0]  row1_duty_o,
  output logic [7:0]  row2_duty_o,
  output logic [1:0]  mode_code_o,
  output logic [31:0] run_time_ms_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import lmfb_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Configuration registers. The user must make writes only while the block is idle;
  // the block itself does not enforce it, and the back end reads them directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_step    <= 8'd1;
      cfg_q.full_level   <= 8'd255;
      cfg_q.dim_level    <= 8'd127;
      cfg_q.blink_period <= 16'd500;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FADE_STEP:    cfg_q.fade_step    <= cfg_wdata_i[7:0];
        REG_FULL_LEVEL:   cfg_q.full_level   <= cfg_wdata_i[7:0];
        REG_DIM_LEVEL:    cfg_q.dim_level    <= cfg_wdata_i[7:0];
        REG_BLINK_PERIOD: cfg_q.blink_period <= cfg_wdata_i;
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  // The front end decodes each item; out-of-range LED indexes on set and read items
  // and the unused action become empty commands that still return a result.
  lmfb_front #(
    .NUM_LEDS (NUM_COLUMNS * NUM_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .led_index_i (led_index_i),
    .led_mode_i  (led_mode_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // The back end owns all LED state, the scan position and the ms counter.
  lmfb_back #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .cfg_i         (cfg_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .column_o      (column_o),
    .row0_duty_o   (row0_duty_o),
    .row1_duty_o   (row1_duty_o),
    .row2_duty_o   (row2_duty_o),
    .mode_code_o   (mode_code_o),
    .run_time_ms_o (run_time_ms_o)
  );

endmodule

FILE: src/lmfb_front.sv
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on lmfb_pkg.
module lmfb_front #(
  parameter int unsigned NUM_LEDS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [4:0]        led_index_i,
  input  logic [1:0]        led_mode_i,
  output logic              cmd_valid_o,
  output lmfb_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);
  import lmfb_pkg::*;

  cmd_t       dec_cmd;
  logic       in_range;
  logic       push;
  cmd_t       fifo_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;

  assign in_range = ({2'b00, led_index_i} < 7'(NUM_LEDS));

  always_comb begin
    dec_cmd.idx  = led_index_i;
    dec_cmd.mode = led_mode_i;
    case (action_i)
      ACT_TICK: dec_cmd.op = OP_TICK;
      ACT_SET:  dec_cmd.op = in_range ? OP_SET : OP_NONE;
      ACT_READ: dec_cmd.op = in_range ? OP_READ : OP_NONE;
      default:  dec_cmd.op = OP_NONE;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= dec_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (cmd_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      case ({push, cmd_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("command queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cnt_q != 2'd0) else $error("command popped from empty queue");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !cmd_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count did not follow a push");

endmodule

FILE: src/lmfb_back.sv
// Back end: sequencer over the per-LED state memory that runs fade, blink, set
// and read commands and holds the result register. Depends on lmfb_pkg.
module lmfb_back #(
  parameter int unsigned NUM_COLUMNS = 8,
  parameter int unsigned NUM_ROWS    = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  lmfb_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  lmfb_pkg::cfg_t    cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        column_o,
  output logic [7:0]        row0_duty_o,
  output logic [7:0]        row1_duty_o,
  output logic [7:0]        row2_duty_o,
  output logic [1:0]        mode_code_o,
  output logic [31:0]       run_time_ms_o
);
  import lmfb_pkg::*;

  localparam int unsigned NUM_LEDS = NUM_COLUMNS * NUM_ROWS;
  localparam int unsigned AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int unsigned CW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int unsigned RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FADE,
    S_GAP,
    S_BLINK,
    S_ONE,
    S_DRAIN,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    K_FADE,
    K_BLINK,
    K_SET,
    K_READ
  } kind_e;

  state_e      state_q;
  cmd_t        cmd_q;
  logic [RW-1:0] row_q;
  logic [AW-1:0] addr_q;
  logic [CW-1:0] col_q;
  logic        half_q;
  logic [31:0] ms_q;
  logic [31:0] ms_next;
  logic        is_tick;
  logic        fin_fire;
  logic [7:0]  res_duty_q [OUT_ROWS];
  logic [1:0]  res_mode_q;
  logic        out_valid_q;
  logic [2:0]  out_col_q;
  logic [7:0]  out_duty_q [OUT_ROWS];
  logic [1:0]  out_mode_q;
  logic [31:0] out_ms_q;

  // Read side of the memory pipeline.
  logic          re;
  kind_e         rkind;
  logic [AW-1:0] raddr;

  // Modify-write side.
  logic          pend_q;
  kind_e         pend_kind_q;
  logic [AW-1:0] pend_addr_q;
  logic [RW-1:0] pend_row_q;
  led_t          mem_q [NUM_LEDS];
  led_t          rdata_q;
  logic          rvld_q;
  logic [NUM_LEDS-1:0] valid_q;
  led_t          ent;
  led_t          wdata;
  logic          we;
  logic [15:0]   tmr_inc;
  logic [1:0]    new_mode;

  always_comb begin
    re    = 1'b0;
    rkind = K_FADE;
    raddr = addr_q;
    case (state_q)
      S_FADE:  re = 1'b1;
      S_BLINK: begin
        re    = 1'b1;
        rkind = K_BLINK;
      end
      S_ONE: begin
        re    = 1'b1;
        rkind = (cmd_q.op == OP_SET) ? K_SET : K_READ;
      end
      default: re = 1'b0;
    endcase
  end

  // Entries never written since reset read as all zero.
  assign ent     = rvld_q ? rdata_q : '0;
  assign tmr_inc = ent.timer + 16'd1;

  always_comb begin
    wdata = ent;
    case (pend_kind_q)
      K_FADE: wdata.fade = fade_next(ent.fade, ent.target, cfg_i.fade_step);
      K_BLINK: begin
        if (ent.blink) begin
          if (tmr_inc == cfg_i.blink_period) begin
            wdata.target = (ent.target == cfg_i.full_level) ? 8'd0 : cfg_i.full_level;
            wdata.timer  = 16'd0;
          end else begin
            wdata.timer = tmr_inc;
          end
        end
      end
      K_SET:   wdata = set_mode(ent, cmd_q.mode, cfg_i);
      default: wdata = ent;
    endcase
  end

  assign we       = pend_q && (pend_kind_q != K_READ);
  assign new_mode = mode_of(wdata, cfg_i);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[pend_addr_q] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
      rvld_q  <= valid_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      pend_q      <= 1'b0;
      pend_kind_q <= K_FADE;
      pend_addr_q <= '0;
      pend_row_q  <= '0;
    end else begin
      if (we) begin
        valid_q[pend_addr_q] <= 1'b1;
      end
      pend_q      <= re;
      pend_kind_q <= rkind;
      pend_addr_q <= raddr;
      pend_row_q  <= row_q;
    end
  end

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign is_tick   = (cmd_q.op == OP_TICK);
  assign ms_next   = ms_q + 32'(is_tick && half_q);
  // The finish step hands over its result once the result register is free or taken.
  assign fin_fire  = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      row_q       <= '0;
      addr_q      <= '0;
      col_q       <= '0;
      half_q      <= 1'b0;
      ms_q        <= '0;
      res_mode_q  <= MODE_OFF;
      res_duty_q  <= '{default: '0};
      out_valid_q <= 1'b0;
      out_col_q   <= '0;
      out_duty_q  <= '{default: '0};
      out_mode_q  <= MODE_OFF;
      out_ms_q    <= '0;
    end else begin
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (pend_q && pend_kind_q == K_FADE) begin
        for (int j = 0; j < OUT_ROWS; j++) begin
          if (int'(pend_row_q) == j) begin
            res_duty_q[j] <= ent.fade;
          end
        end
      end
      if (pend_q && (pend_kind_q == K_SET || pend_kind_q == K_READ)) begin
        res_mode_q <= new_mode;
      end

      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q      <= cmd_i;
            res_duty_q <= '{default: '0};
            res_mode_q <= MODE_OFF;
            case (cmd_i.op)
              OP_TICK: begin
                row_q   <= '0;
                addr_q  <= AW'(col_q);
                state_q <= S_FADE;
              end
              OP_SET, OP_READ: begin
                addr_q  <= AW'(cmd_i.idx);
                state_q <= S_ONE;
              end
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_FADE: begin
          if (row_q == RW'(NUM_ROWS - 1)) begin
            state_q <= half_q ? S_GAP : S_DRAIN;
          end else begin
            row_q  <= row_q + RW'(1);
            addr_q <= addr_q + AW'(NUM_COLUMNS);
          end
        end
        S_GAP: begin
          addr_q  <= '0;
          state_q <= S_BLINK;
        end
        S_BLINK: begin
          if (addr_q == AW'(NUM_LEDS - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        S_ONE:   state_q <= S_DRAIN;
        S_DRAIN: state_q <= S_FIN;
        S_FIN: begin
          if (fin_fire) begin
            out_col_q   <= is_tick ? 3'(col_q) : 3'd0;
            out_duty_q  <= res_duty_q;
            out_mode_q  <= res_mode_q;
            out_ms_q    <= ms_next;
            if (is_tick) begin
              col_q  <= (col_q == CW'(NUM_COLUMNS - 1)) ? '0 : col_q + CW'(1);
              half_q <= ~half_q;
              ms_q   <= ms_next;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign column_o      = out_col_q;
  assign row0_duty_o   = out_duty_q[0];
  assign row1_duty_o   = out_duty_q[1];
  assign row2_duty_o   = out_duty_q[2];
  assign mode_code_o   = out_mode_q;
  assign run_time_ms_o = out_ms_q;

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> pend_addr_q != raddr) else $error("read and write hit the same LED entry");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> !pend_q) else $error("result formed with a write still pending");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN)) else $error("result raised outside finish");

  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> state_q != S_IDLE) else $error("popped command was not started");

endmodule

FILE: sim/tb_led_matrix_fade_blink_scanner_unit.sv
// Self-checking testbench for led_matrix_fade_blink_scanner_unit: directed table, then random
// scan/set/read traffic under several register settings, checked against a local predictor.
// Depends on lmfb_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_led_matrix_fade_blink_scanner_unit;
  import lmfb_pkg::*;

  localparam int unsigned LED_COLS  = 8;
  localparam int unsigned LED_ROWS  = 3;
  localparam int unsigned LED_COUNT = LED_COLS * LED_ROWS;

  // The action code the block leaves unused; it must answer with zero column, duties and mode.
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int unsigned DIR_ROWS   = 25;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 116;
  localparam int unsigned MAX_REPORTS = 10;

  // One result item as it appears on the output ports.
  typedef struct packed {
    logic [2:0]  column;
    logic [7:0]  duty0;
    logic [7:0]  duty1;
    logic [7:0]  duty2;
    logic [1:0]  mode;
    logic [31:0] ms;
  } scan_result_t;

  // One row of the directed table. When typed is set, exp holds the result read off
  // by hand and is used instead of the predictor's answer.
  typedef struct packed {
    logic [1:0]   act;
    logic [4:0]   idx;
    logic [1:0]   mode;
    logic         typed;
    scan_result_t exp;
  } stim_row_t;

  localparam scan_result_t NO_RES = '0;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [4:0]  led_index_i;
  logic [1:0]  led_mode_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  column_o;
  logic [7:0]  row0_duty_o;
  logic [7:0]  row1_duty_o;
  logic [7:0]  row2_duty_o;
  logic [1:0]  mode_code_o;
  logic [31:0] run_time_ms_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_wdata_i;

  led_matrix_fade_blink_scanner_unit #(
    .NUM_COLUMNS(LED_COLS),
    .NUM_ROWS   (LED_ROWS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .led_index_i  (led_index_i),
    .led_mode_i   (led_mode_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .column_o     (column_o),
    .row0_duty_o  (row0_duty_o),
    .row1_duty_o  (row1_duty_o),
    .row2_duty_o  (row2_duty_o),
    .mode_code_o  (mode_code_o),
    .run_time_ms_o(run_time_ms_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Predicted copy of the block's registers and per-LED state.
  logic [7:0]  fade_step_q;
  logic [7:0]  full_lvl_q;
  logic [7:0]  dim_lvl_q;
  logic [15:0] blink_period_q;
  logic [7:0]  led_target[LED_COUNT];
  logic [7:0]  led_fade[LED_COUNT];
  logic        led_blinking[LED_COUNT];
  logic [15:0] led_blink_ms[LED_COUNT];
  logic [2:0]  scan_col_q;
  logic        half_ms_q;
  logic [31:0] ms_count_q;

  // Results still owed by the block, oldest first.
  scan_result_t pending_results[$];

  stim_row_t   dir_tbl[DIR_ROWS];
  logic        quiet;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned blink_flips;
  int unsigned ready_hold;

  // The 10 ns clock runs freely for the whole simulation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on a handshake; far above any correct run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Mode of one LED as the block reports it: blink wins, then full, then dim.
  function automatic logic [1:0] led_mode_code(int n);
    logic [1:0] m;
    if (led_blinking[n]) begin
      m = MODE_BLINK;
    end else if (led_target[n] == full_lvl_q) begin
      m = MODE_FULL;
    end else if (led_target[n] == dim_lvl_q) begin
      m = MODE_DIM;
    end else begin
      m = MODE_OFF;
    end
    return m;
  endfunction

  // Advances the predicted state by one accepted item and returns the result it owes.
  function automatic scan_result_t predict_scan_result(logic [1:0] act, logic [4:0] idx,
                                                       logic [1:0] mode);
    scan_result_t r;
    int           n;
    int           cur;
    int           goal;
    logic [7:0]   duty[LED_ROWS];
    r = '0;
    if (act == ACT_TICK) begin
      r.column = scan_col_q;
      for (int row = 0; row < LED_ROWS; row++) begin
        n = scan_col_q + row * LED_COLS;
        cur = led_fade[n];
        goal = led_target[n];
        duty[row] = led_fade[n];
        // Step toward the target and never overshoot it.
        if (cur < goal) begin
          cur = cur + fade_step_q;
          if (cur > goal) cur = goal;
        end else if (cur > goal) begin
          cur = cur - fade_step_q;
          if (cur < goal) cur = goal;
        end
        led_fade[n] = cur[7:0];
      end
      r.duty0 = duty[0];
      r.duty1 = duty[1];
      r.duty2 = duty[2];
      scan_col_q = (scan_col_q == LED_COLS - 1) ? 3'd0 : scan_col_q + 3'd1;
      // Every second tick is a whole millisecond: count it and run the blink timers.
      if (half_ms_q) begin
        ms_count_q = ms_count_q + 32'd1;
        for (int i = 0; i < LED_COUNT; i++) begin
          if (led_blinking[i]) begin
            led_blink_ms[i] = led_blink_ms[i] + 16'd1;
            if (led_blink_ms[i] == blink_period_q) begin
              led_target[i] = (led_target[i] == full_lvl_q) ? 8'd0 : full_lvl_q;
              led_blink_ms[i] = 16'd0;
              blink_flips++;
            end
          end
        end
      end
      half_ms_q = ~half_ms_q;
    end else if (act == ACT_SET && idx < LED_COUNT) begin
      n = idx;
      if (mode == MODE_BLINK) begin
        // Blinking starts in the phase opposite to what the LED is showing.
        led_blinking[n] = 1'b1;
        led_target[n] = (led_target[n] == full_lvl_q || led_target[n] == dim_lvl_q) ?
                        8'd0 : full_lvl_q;
      end else begin
        if (led_blinking[n]) begin
          led_blinking[n] = 1'b0;
          led_blink_ms[n] = 16'd0;
        end
        case (mode)
          MODE_OFF: led_target[n] = 8'd0;
          MODE_DIM: led_target[n] = dim_lvl_q;
          default:  led_target[n] = full_lvl_q;
        endcase
      end
      r.mode = led_mode_code(n);
    end else if (act == ACT_READ && idx < LED_COUNT) begin
      r.mode = led_mode_code(idx);
    end
    r.ms = ms_count_q;
    return r;
  endfunction

  // Presents one item, waits for it to be taken and records what it should produce.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic [1:0] act, logic [4:0] idx, logic [1:0] mode,
                           logic typed, scan_result_t typed_res);
    scan_result_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    action_i    = act;
    led_index_i = idx;
    led_mode_i  = mode;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    res = predict_scan_result(act, idx, mode);
    pending_results.push_back(typed ? typed_res : res);
    items_sent++;
    if (act == ACT_TICK) ticks_sent++;
    @(negedge clk_i);
  endtask

  // Stops sending and waits until the block has returned every owed result.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Writes one register while the block is idle and mirrors it in the predictor.
  task automatic write_reg(logic [1:0] index, logic [15:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = index;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (index)
      REG_FADE_STEP:  fade_step_q = data[7:0];
      REG_FULL_LEVEL: full_lvl_q = data[7:0];
      REG_DIM_LEVEL:  dim_lvl_q = data[7:0];
      default:        blink_period_q = data;
    endcase
  endtask

  // Register settings for each random phase. The extremes come first; the random
  // settings also put junk in the unused upper data bits of the byte registers.
  task automatic apply_setting(int unsigned phase);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    case (phase)
      0: begin
        write_reg(REG_FADE_STEP, 16'd1);
        write_reg(REG_FULL_LEVEL, 16'd255);
        write_reg(REG_DIM_LEVEL, 16'd127);
        write_reg(REG_BLINK_PERIOD, 16'd2);
      end
      1: begin
        write_reg(REG_FADE_STEP, 16'd255);
        write_reg(REG_FULL_LEVEL, 16'd255);
        write_reg(REG_DIM_LEVEL, 16'd0);
        write_reg(REG_BLINK_PERIOD, 16'd1);
      end
      2: begin
        // A zero step freezes every fade level where it stands.
        write_reg(REG_FADE_STEP, 16'd0);
        write_reg(REG_FULL_LEVEL, 16'd200);
        write_reg(REG_DIM_LEVEL, 16'd100);
        write_reg(REG_BLINK_PERIOD, 16'd3);
      end
      3: begin
        write_reg(REG_FADE_STEP, 16'd37);
        write_reg(REG_FULL_LEVEL, 16'd0);
        write_reg(REG_DIM_LEVEL, 16'd0);
        write_reg(REG_BLINK_PERIOD, 16'hFFFF);
      end
      4: begin
        // A zero period only toggles when the timer wraps, far beyond this phase.
        write_reg(REG_FADE_STEP, {junk, 8'($urandom_range(0, 255))});
        write_reg(REG_FULL_LEVEL, {~junk, 8'($urandom_range(0, 255))});
        write_reg(REG_DIM_LEVEL, {junk, 8'($urandom_range(0, 255))});
        write_reg(REG_BLINK_PERIOD, 16'd0);
      end
      5: begin
        // Full and dim share one level, so full wins the mode decode.
        write_reg(REG_FADE_STEP, 16'd8);
        write_reg(REG_FULL_LEVEL, 16'd128);
        write_reg(REG_DIM_LEVEL, 16'd128);
        write_reg(REG_BLINK_PERIOD, 16'd5);
      end
      6: begin
        write_reg(REG_FADE_STEP, {junk, 8'($urandom_range(1, 255))});
        write_reg(REG_FULL_LEVEL, {~junk, 8'($urandom_range(0, 255))});
        write_reg(REG_DIM_LEVEL, {junk, 8'($urandom_range(0, 255))});
        write_reg(REG_BLINK_PERIOD, 16'($urandom_range(1, 6)));
      end
      default: begin
        write_reg(REG_FADE_STEP, 16'd1);
        write_reg(REG_FULL_LEVEL, 16'd255);
        write_reg(REG_DIM_LEVEL, 16'd127);
        write_reg(REG_BLINK_PERIOD, 16'd4);
      end
    endcase
  endtask

  // Random traffic: mostly ticks so fades and blinks play out, with sets aimed at
  // real LEDs, some reads, a few addresses past the matrix and a few spare actions.
  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  act;
    logic [4:0]  idx;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      act = ACT_TICK;
    end else if (pick < 80) begin
      act = ACT_SET;
    end else if (pick < 95) begin
      act = ACT_READ;
    end else begin
      act = ACT_SPARE;
    end
    idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(LED_COUNT, 31)) :
                                        5'($urandom_range(0, LED_COUNT - 1));
    send_item(act, idx, 2'($urandom_range(0, 3)), 1'b0, NO_RES);
  endtask

  // The receiver stalls in random bursts, except in the final stretch of the run.
  always @(negedge clk_i) begin
    if (ready_hold != 0 && !quiet) begin
      ready_hold  <= ready_hold - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && rst_ni && $urandom_range(0, 7) == 0) begin
      ready_hold  <= $urandom_range(0, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Every result taken by the receiver is checked against the oldest one owed.
  always @(posedge clk_i) begin : check_results
    scan_result_t got;
    scan_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{column_o, row0_duty_o, row1_duty_o, row2_duty_o, mode_code_o, run_time_ms_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing owed: col %0d duty %0d/%0d/%0d mode %0d ms %0d",
                   $realtime, got.column, got.duty0, got.duty1, got.duty2, got.mode, got.ms);
      end else begin
        want = pending_results.pop_front();
        if (got.column !== want.column || got.duty0 !== want.duty0 ||
            got.duty1 !== want.duty1 || got.duty2 !== want.duty2 ||
            got.mode !== want.mode || got.ms !== want.ms) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result %0d expected col %0d duty %0d/%0d/%0d mode %0d ms %0d",
                     $realtime, results_seen, want.column, want.duty0, want.duty1,
                     want.duty2, want.mode, want.ms);
            $display("%0t: result %0d got      col %0d duty %0d/%0d/%0d mode %0d ms %0d",
                     $realtime, results_seen, got.column, got.duty0, got.duty1,
                     got.duty2, got.mode, got.ms);
          end
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_TICK;
    led_index_i  = 5'd0;
    led_mode_i   = MODE_OFF;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_FADE_STEP;
    cfg_wdata_i  = 16'd0;
    quiet        = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    ticks_sent   = 0;
    results_seen = 0;
    blink_flips  = 0;
    ready_hold   = 0;

    // Predicted state after reset.
    fade_step_q    = 8'd1;
    full_lvl_q     = 8'd255;
    dim_lvl_q      = 8'd127;
    blink_period_q = 16'd500;
    for (int i = 0; i < LED_COUNT; i++) begin
      led_target[i]   = 8'd0;
      led_fade[i]     = 8'd0;
      led_blinking[i] = 1'b0;
      led_blink_ms[i] = 16'd0;
    end
    scan_col_q = 3'd0;
    half_ms_q  = 1'b0;
    ms_count_q = 32'd0;

    // Directed rows at reset settings. The first ticks, the out-of-range and spare
    // items, and the mode answers of sets and reads are typed in by hand; the closing
    // sweep of ticks over all columns is left to the predictor.
    dir_tbl = '{
      '{ACT_READ,  5'd0,  MODE_OFF,   1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_OFF,   32'd0}},
      '{ACT_TICK,  5'd0,  MODE_OFF,   1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_OFF,   32'd0}},
      '{ACT_TICK,  5'd31, MODE_BLINK, 1'b1, '{3'd1, 8'd0, 8'd0, 8'd0, MODE_OFF,   32'd1}},
      '{ACT_READ,  5'd24, MODE_OFF,   1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_OFF,   32'd1}},
      '{ACT_SET,   5'd31, MODE_BLINK, 1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_OFF,   32'd1}},
      '{ACT_SPARE, 5'd5,  MODE_FULL,  1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_OFF,   32'd1}},
      '{ACT_SET,   5'd0,  MODE_FULL,  1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_FULL,  32'd1}},
      '{ACT_SET,   5'd8,  MODE_DIM,   1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_DIM,   32'd1}},
      '{ACT_SET,   5'd16, MODE_BLINK, 1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_BLINK, 32'd1}},
      '{ACT_SET,   5'd23, MODE_OFF,   1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_OFF,   32'd1}},
      '{ACT_SET,   5'd7,  MODE_BLINK, 1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_BLINK, 32'd1}},
      '{ACT_SET,   5'd7,  MODE_BLINK, 1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_BLINK, 32'd1}},
      '{ACT_READ,  5'd16, MODE_OFF,   1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_BLINK, 32'd1}},
      '{ACT_SET,   5'd16, MODE_OFF,   1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_OFF,   32'd1}},
      '{ACT_SET,   5'd15, MODE_FULL,  1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_FULL,  32'd1}},
      '{ACT_SET,   5'd15, MODE_BLINK, 1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_BLINK, 32'd1}},
      '{ACT_SET,   5'd15, MODE_DIM,   1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, MODE_DIM,   32'd1}},
      '{ACT_TICK,  5'd0,  MODE_OFF,   1'b0, NO_RES},
      '{ACT_TICK,  5'd0,  MODE_OFF,   1'b0, NO_RES},
      '{ACT_TICK,  5'd0,  MODE_OFF,   1'b0, NO_RES},
      '{ACT_TICK,  5'd0,  MODE_OFF,   1'b0, NO_RES},
      '{ACT_TICK,  5'd0,  MODE_OFF,   1'b0, NO_RES},
      '{ACT_TICK,  5'd0,  MODE_OFF,   1'b0, NO_RES},
      '{ACT_TICK,  5'd0,  MODE_OFF,   1'b0, NO_RES},
      '{ACT_TICK,  5'd0,  MODE_OFF,   1'b0, NO_RES}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_tbl[i].act, dir_tbl[i].idx, dir_tbl[i].mode, dir_tbl[i].typed,
                dir_tbl[i].exp);
    end

    // Random phases, each under its own register setting. Registers change only
    // once the block has handed back every result, so it is idle at the write.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      apply_setting(p);
      // The last phase runs without any idling on either side.
      quiet = (p == NUM_PHASES - 1);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        // Now and then let the block run completely dry before the next item.
        if (!quiet && $urandom_range(0, 49) == 0) wait_drained();
        send_random_item();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);

    if (pending_results.size() != 0) mismatches += pending_results.size();
    $display("Sent %0d items (%0d scan ticks) over %0d register settings; %0d results checked.",
             items_sent, ticks_sent, NUM_PHASES + 1, results_seen);
    $display("Blink phase toggles predicted: %0d; mismatches: %0d.", blink_flips, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
